[hdl/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int U8U16_QDEPTH = 4;

  localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] CP_BMP_MAX   = 21'h00FFFF;
  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
  localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;

  localparam logic [7:0] LEAD1_MAX = 8'h7F;
  localparam logic [7:0] CONT_MAX  = 8'hBF;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MAX = 8'hF7;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_error;
    logic        run_last;
    logic        text_done;
  } out_beat_t;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [20:0] cp;
    logic [1:0]  togo;
    logic        skip;
  } dec_state_t;

  // All results caused by one input byte
  typedef struct packed {
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        two;
    logic        err;
    logic        done;
  } res_group_t;

endpackage

[hdl/u8u16_decode.sv]
// ----------------------------------------------------------------------------
// u8u16_decode
// Per-byte UTF-8 decode step: next state and the result group it causes.
// ----------------------------------------------------------------------------
module u8u16_decode
  import u8u16_pkg::*;
(
  input  in_beat_t   beat,
  input  dec_state_t st,
  output dec_state_t st_nxt,
  output logic       has_res,
  output res_group_t res
);

  logic [7:0]  b;
  logic        eot;
  logic [20:0] cp_w;
  logic [1:0]  togo_w;
  logic        bad;
  logic [20:0] supp;

  assign b    = beat.in_byte;
  assign eot  = beat.end_of_text;
  assign supp = cp_w - CP_SUPP_BASE;

  always_comb begin
    cp_w    = st.cp;
    togo_w  = st.togo;
    bad     = 1'b0;
    st_nxt  = st;
    has_res = 1'b0;
    res     = '0;
    res.done = eot;

    if (st.skip) begin
      // swallow the rest of a failed text
      if (eot) begin
        st_nxt.skip = 1'b0;
      end
    end else begin
      if (st.togo == 2'd0) begin
        if (b <= LEAD1_MAX) begin
          cp_w = {13'd0, b};
        end else if (b <= CONT_MAX) begin
          bad = 1'b1;
        end else if (b <= LEAD2_MAX) begin
          cp_w   = {16'd0, b[4:0]};
          togo_w = 2'd1;
        end else if (b <= LEAD3_MAX) begin
          cp_w   = {17'd0, b[3:0]};
          togo_w = 2'd2;
        end else if (b <= LEAD4_MAX) begin
          cp_w   = {18'd0, b[2:0]};
          togo_w = 2'd3;
        end else begin
          bad = 1'b1;
        end
      end else begin
        if (b[7:6] != 2'b10) begin
          bad = 1'b1;
        end
        cp_w   = {st.cp[14:0], b[5:0]};
        togo_w = st.togo - 2'd1;
      end

      if (!bad) begin
        if (togo_w != 2'd0) begin
          if (eot) begin
            bad = 1'b1;
          end else begin
            st_nxt.cp   = cp_w;
            st_nxt.togo = togo_w;
          end
        end else if ((cp_w >= CP_SURR_LO && cp_w <= CP_SURR_HI) || cp_w > CP_MAX) begin
          bad = 1'b1;
        end else begin
          st_nxt.cp   = '0;
          st_nxt.togo = 2'd0;
          has_res     = 1'b1;
          if (cp_w <= CP_BMP_MAX) begin
            res.unit0 = cp_w[15:0];
          end else begin
            res.two   = 1'b1;
            res.unit0 = {HI_SURR_TAG, supp[19:10]};
            res.unit1 = {LO_SURR_TAG, supp[9:0]};
          end
        end
      end

      if (bad) begin
        st_nxt.cp   = '0;
        st_nxt.togo = 2'd0;
        st_nxt.skip = !eot;
        has_res     = 1'b1;
        res.unit0   = '0;
        res.unit1   = '0;
        res.two     = 1'b0;
        res.err     = 1'b1;
        // an error beat always closes the text
        res.done    = 1'b1;
      end
    end
  end

endmodule

[hdl/u8u16_outq.sv]
// ----------------------------------------------------------------------------
// u8u16_outq
// Result queue: holds result groups and sends them out one beat at a time.
// ----------------------------------------------------------------------------
module u8u16_outq
  import u8u16_pkg::*;
#(
  parameter int DEPTH = U8U16_QDEPTH
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  res_group_t push_data,
  output logic       full,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  res_group_t     mem [DEPTH];
  logic [AW-1:0]  wr_r, wr_nxt;
  logic [AW-1:0]  rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           sub_r, sub_nxt;
  res_group_t     head;
  logic           beat_go;
  logic           pop;

  assign head      = mem[rd_r];
  assign full      = (cnt_r == FULL_CNT);
  assign out_valid = (cnt_r != '0);
  assign beat_go   = out_valid && !out_stall;
  assign pop       = beat_go && (!head.two || sub_r);

  always_comb begin
    if (head.two && !sub_r) begin
      out_data.code_unit = head.unit0;
      out_data.is_error  = 1'b0;
      out_data.run_last  = 1'b0;
      out_data.text_done = 1'b0;
    end else if (head.two) begin
      out_data.code_unit = head.unit1;
      out_data.is_error  = 1'b0;
      out_data.run_last  = 1'b1;
      out_data.text_done = head.done;
    end else begin
      out_data.code_unit = head.unit0;
      out_data.is_error  = head.err;
      out_data.run_last  = 1'b1;
      out_data.text_done = head.done;
    end
  end

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    sub_nxt = sub_r;
    if (push) begin
      wr_nxt = (wr_r == LAST_IDX) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt  = (rd_r == LAST_IDX) ? '0 : rd_r + 1'b1;
      sub_nxt = 1'b0;
    end else if (beat_go) begin
      // first half of a surrogate pair went out
      sub_nxt = 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
      sub_r <= 1'b0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
      sub_r <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

endmodule

[hdl/utf8_to_utf16_transcoder.sv]
// Datapath: an accepted byte is registered, decoded combinationally, and its
// result group goes into the result queue, whose head drives the output.
// Throughput: one byte per cycle unless the queue is full; a byte above U+FFFF
// needs two output beats, so beat rate bounds input via a QUEUE_DEPTH-group queue.
// Reset: synchronous active-low rst_n clears decode state, the input stage and
// the result queue; no text is in progress afterwards.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Streaming UTF-8 to UTF-16 converter with per-text error abort.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
#(
  parameter int QUEUE_DEPTH = U8U16_QDEPTH
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  in_beat_t   in_r;
  logic       in_vld_r;
  dec_state_t st_r;
  dec_state_t st_nxt;
  logic       has_res;
  res_group_t res;
  logic       q_full;
  logic       step;

  // The input stage drains whenever the queue has a free group slot
  assign step     = in_vld_r && !q_full;
  assign in_stall = in_vld_r && q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      st_r     <= '0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (step) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_r <= in_data;
    end
  end

  u8u16_decode u_decode (
    .beat    (in_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .has_res (has_res),
    .res     (res)
  );

  u8u16_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step && has_res),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[hdl/u8u16_checker.sv]
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks on the transcoder's result stream.
// ----------------------------------------------------------------------------
module u8u16_checker
  import u8u16_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // error beat always closes the text with a zero unit
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_error |->
      out_data.run_last && out_data.text_done && out_data.code_unit == '0)
    else $error("malformed error beat");

  // only a high surrogate is a non-final beat of a byte
  a_mid_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_last |->
      !out_data.text_done && !out_data.is_error &&
      out_data.code_unit[15:10] == HI_SURR_TAG)
    else $error("non-final beat is not a high surrogate");

  // a taken high surrogate is followed at once by its low half
  a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.run_last |=>
      out_valid && out_data.run_last && out_data.code_unit[15:10] == LO_SURR_TAG)
    else $error("low surrogate does not follow high surrogate");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
